// ===== rtl/htifsm_pkg.sv =====
// ----------------------------------------------------------------------------
// htifsm_pkg
// Codes, widths and reset values shared by the heater interlock.
// ----------------------------------------------------------------------------
package htifsm_pkg;

    localparam int TEMP_W  = 12;
    localparam int PWM_W   = 16;
    localparam int OP_W    = 3;
    localparam int ALARM_W = 2;

    // Event codes carried in the request tuser
    localparam logic [OP_W-1:0] OP_FOUND   = 3'd0;
    localparam logic [OP_W-1:0] OP_MISSING = 3'd1;
    localparam logic [OP_W-1:0] OP_SAMPLE  = 3'd2;
    localparam logic [OP_W-1:0] OP_REQ_ON  = 3'd3;
    localparam logic [OP_W-1:0] OP_REQ_OFF = 3'd4;

    // Alarm and buzzer codes
    localparam logic [ALARM_W-1:0] ALARM_NONE     = 2'd0;
    localparam logic [ALARM_W-1:0] ALARM_OVERHEAT = 2'd1;
    localparam logic [ALARM_W-1:0] ALARM_FAIL     = 2'd2;

    // Register indexes on the configuration port
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_PWM_FULL  = 1'b1;

    // -127 C in 1/16 degree steps
    localparam logic signed [TEMP_W-1:0] INVALID_READING = -12'sd2032;
    localparam logic signed [TEMP_W-1:0] THRESHOLD_RST   = 12'sd1280;
    localparam logic [PWM_W-1:0]         PWM_FULL_RST    = 16'd255;

endpackage

// ===== rtl/heater_thermal_interlock_fsm.sv =====
// ----------------------------------------------------------------------------
// heater_thermal_interlock_fsm
// Safety interlock for one heater and one temperature sensor.
// ----------------------------------------------------------------------------
// Each request is one event (sensor found, sensor missing, temperature sample,
// heater on, heater off) and gives exactly one result: the mode, PWM drive,
// load request, alarm and buzzer codes and sensor presence after the event,
// plus whether an on/off request was accepted. A request passes through an
// input register, then next-state logic writes the interlock state and the
// result register together, and a new request is taken every cycle while
// the result side keeps up. Temperatures are signed 1/16 degree C.
// Threshold and full-scale PWM are set over the APB port at 0x0 and 0x4 and
// act from the next event on.
// ----------------------------------------------------------------------------
module heater_thermal_interlock_fsm
(
    input  logic        clk,
    input  logic        rst_n,
    // request: tdata = temperature[11:0], zero padded
    //          tuser = operation[2:0], sample_valid[3]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [3:0]  s_tuser,
    // result: tdata = mode[2:0], pwm[18:3], load_requested[19], alarm_code[21:20],
    //         buzzer_code[23:22], sensor_present[24], accepted[25], zero padded
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        MODE_BOOT  = 3'd0,
        MODE_SCAN  = 3'd1,
        MODE_SAFE  = 3'd2,
        MODE_MON   = 3'd3,
        MODE_ON    = 3'd4,
        MODE_ALARM = 3'd5,
        MODE_FAIL  = 3'd6
    } mode_t;

    localparam int TW = htifsm_pkg::TEMP_W;
    localparam int PW = htifsm_pkg::PWM_W;
    localparam int AW = htifsm_pkg::ALARM_W;

    // configuration registers
    logic signed [TW-1:0] threshold_reg;
    logic [PW-1:0]        pwm_full_reg;

    // input stage
    logic                          in_valid_reg;
    logic [htifsm_pkg::OP_W-1:0]   in_op_reg;
    logic                          in_sv_reg;
    logic signed [TW-1:0]          in_temp_reg;

    // interlock state
    mode_t                mode_reg, mode_next;
    logic [PW-1:0]        pwm_reg, pwm_next;
    logic                 load_reg, load_next;
    logic [AW-1:0]        alarm_reg, alarm_next;
    logic [AW-1:0]        buzzer_reg, buzzer_next;
    logic                 present_reg, present_next;
    logic                 rvalid_reg, rvalid_next;
    logic signed [TW-1:0] reading_reg, reading_next;
    logic                 acc_next;

    // result stage
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic advance;
    logic cfg_wr;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    always_comb
    begin
        if (paddr[2] == htifsm_pkg::REG_THRESHOLD)
            prdata = {{(32-TW){threshold_reg[TW-1]}}, threshold_reg};
        else
            prdata = {{(32-PW){1'b0}}, pwm_full_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= htifsm_pkg::THRESHOLD_RST;
            pwm_full_reg  <= htifsm_pkg::PWM_FULL_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == htifsm_pkg::REG_THRESHOLD)
                threshold_reg <= pwdata[TW-1:0];
            else
                pwm_full_reg <= pwdata[PW-1:0];
        end
    end

    // Next state for one event; a refresh of the drive always closes its branch.
    always_comb
    begin
        logic refresh;
        logic active;
        logic run;

        mode_next    = mode_reg;
        pwm_next     = pwm_reg;
        load_next    = load_reg;
        alarm_next   = alarm_reg;
        buzzer_next  = buzzer_reg;
        present_next = present_reg;
        rvalid_next  = rvalid_reg;
        reading_next = reading_reg;
        acc_next     = 1'b0;
        refresh      = 1'b0;
        run          = 1'b0;
        active       = (mode_reg == MODE_MON) || (mode_reg == MODE_ON);

        case (in_op_reg)
            htifsm_pkg::OP_FOUND:
            begin
                present_next = 1'b1;
                if (mode_reg inside {MODE_SCAN, MODE_SAFE})
                begin
                    mode_next   = MODE_MON;
                    alarm_next  = htifsm_pkg::ALARM_NONE;
                    buzzer_next = htifsm_pkg::ALARM_NONE;
                    load_next   = 1'b0;
                end
                refresh = 1'b1;
            end
            htifsm_pkg::OP_MISSING:
            begin
                present_next = 1'b0;
                load_next    = 1'b0;
                pwm_next     = '0;
                if (mode_reg == MODE_SCAN)
                    mode_next = MODE_SAFE;
            end
            htifsm_pkg::OP_SAMPLE:
            begin
                rvalid_next  = in_sv_reg;
                reading_next = in_sv_reg ? in_temp_reg : htifsm_pkg::INVALID_READING;
                if (!in_sv_reg)
                begin
                    if (mode_reg inside {MODE_MON, MODE_ON, MODE_ALARM})
                    begin
                        load_next   = 1'b0;
                        mode_next   = MODE_FAIL;
                        alarm_next  = htifsm_pkg::ALARM_FAIL;
                        buzzer_next = htifsm_pkg::ALARM_FAIL;
                    end
                    pwm_next = '0;
                end
                else if (mode_reg inside {MODE_FAIL, MODE_SAFE})
                begin
                    mode_next   = MODE_MON;
                    alarm_next  = htifsm_pkg::ALARM_NONE;
                    buzzer_next = htifsm_pkg::ALARM_NONE;
                    load_next   = 1'b0;
                    refresh     = 1'b1;
                end
                else if (mode_reg == MODE_ALARM)
                begin
                    if (in_temp_reg < threshold_reg)
                    begin
                        mode_next   = MODE_MON;
                        alarm_next  = htifsm_pkg::ALARM_NONE;
                        buzzer_next = htifsm_pkg::ALARM_NONE;
                        refresh     = 1'b1;
                    end
                end
                else if (in_temp_reg >= threshold_reg)
                begin
                    load_next   = 1'b0;
                    mode_next   = MODE_ALARM;
                    alarm_next  = htifsm_pkg::ALARM_OVERHEAT;
                    buzzer_next = htifsm_pkg::ALARM_OVERHEAT;
                    pwm_next    = '0;
                end
                else
                begin
                    refresh = 1'b1;
                end
            end
            htifsm_pkg::OP_REQ_ON:
            begin
                if (active && rvalid_reg && (reading_reg < threshold_reg))
                begin
                    load_next = 1'b1;
                    refresh   = 1'b1;
                    acc_next  = 1'b1;
                end
            end
            htifsm_pkg::OP_REQ_OFF:
            begin
                if (active)
                begin
                    load_next = 1'b0;
                    refresh   = 1'b1;
                    acc_next  = 1'b1;
                end
            end
            default:
            begin
                // unused codes leave the state alone
            end
        endcase

        if (refresh)
        begin
            active = (mode_next == MODE_MON) || (mode_next == MODE_ON);
            run    = load_next && rvalid_next && (reading_next < threshold_reg) && active;
            pwm_next = run ? pwm_full_reg : '0;
            if (active)
                mode_next = load_next ? MODE_ON : MODE_MON;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_SCAN;
            pwm_reg       <= '0;
            load_reg      <= 1'b0;
            alarm_reg     <= htifsm_pkg::ALARM_NONE;
            buzzer_reg    <= htifsm_pkg::ALARM_NONE;
            present_reg   <= 1'b0;
            rvalid_reg    <= 1'b0;
            reading_reg   <= htifsm_pkg::INVALID_READING;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            // commit the event when it moves into the result register
            if (advance && in_valid_reg)
            begin
                mode_reg    <= mode_next;
                pwm_reg     <= pwm_next;
                load_reg    <= load_next;
                alarm_reg   <= alarm_next;
                buzzer_reg  <= buzzer_next;
                present_reg <= present_next;
                rvalid_reg  <= rvalid_next;
                reading_reg <= reading_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser[2:0];
            in_sv_reg   <= s_tuser[3];
            in_temp_reg <= s_tdata[TW-1:0];
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg <= {6'd0, acc_next, present_next, buzzer_next, alarm_next,
                             load_next, pwm_next, mode_next};
        end
    end

endmodule

// ===== tb/heater_thermal_interlock_fsm_tb.sv =====
// ----------------------------------------------------------------------------
// heater_thermal_interlock_fsm_tb
// Self-checking bench for the heater thermal interlock.
// ----------------------------------------------------------------------------
// A queue of events feeds a burst-mode driver on the request stream. Every
// accepted request runs through an interlock model kept here, and the
// predicted status is checked field by field against each result. The run
// starts with a directed walk through the modes, then goes through several
// threshold and full-scale settings with weighted random events while the
// result side stalls in changing patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module heater_thermal_interlock_fsm_tb;

    typedef enum logic [2:0]
    {
        MODE_BOOT,
        MODE_SCAN,
        MODE_SAFE,
        MODE_MONITOR,
        MODE_HEATING,
        MODE_ALARM,
        MODE_SENSOR_FAIL
    } mode_t;

    typedef struct packed
    {
        logic [htifsm_pkg::OP_W-1:0]   op;
        logic                          valid;
        logic [htifsm_pkg::TEMP_W-1:0] temp;
    } event_t;

    typedef struct packed
    {
        logic [2:0]                     mode;
        logic [htifsm_pkg::PWM_W-1:0]   pwm;
        logic                           load;
        logic [htifsm_pkg::ALARM_W-1:0] alarm;
        logic [htifsm_pkg::ALARM_W-1:0] buzzer;
        logic                           present;
        logic                           accepted;
    } status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    heater_thermal_interlock_fsm i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 clk = ~clk;

    // interlock model state and configuration
    mode_t                                st_mode = MODE_SCAN;
    logic [htifsm_pkg::PWM_W-1:0]         st_pwm = '0;
    logic                                 st_load = 1'b0;
    logic [htifsm_pkg::ALARM_W-1:0]       st_alarm = htifsm_pkg::ALARM_NONE;
    logic [htifsm_pkg::ALARM_W-1:0]       st_buzzer = htifsm_pkg::ALARM_NONE;
    logic                                 st_present = 1'b0;
    logic                                 st_reading_ok = 1'b0;
    logic signed [htifsm_pkg::TEMP_W-1:0] st_reading = htifsm_pkg::INVALID_READING;
    logic signed [htifsm_pkg::TEMP_W-1:0] cfg_threshold = htifsm_pkg::THRESHOLD_RST;
    logic [htifsm_pkg::PWM_W-1:0]         cfg_pwm_full = htifsm_pkg::PWM_FULL_RST;

    event_t      event_q[$];
    status_t     status_q[$];
    int unsigned events_queued = 0;
    int unsigned events_taken = 0;
    int unsigned results_seen = 0;
    int unsigned n_mismatch = 0;

    logic        req_taken = 1'b0;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    logic        drain_hold = 1'b0;
    int unsigned cycle_cnt = 0;
    int unsigned ready_style = 0;

    function automatic logic heater_active();
        return st_mode == MODE_MONITOR || st_mode == MODE_HEATING;
    endfunction

    function automatic void refresh_drive();
        logic run;
        run = st_load && st_reading_ok && (st_reading < cfg_threshold) && heater_active();
        st_pwm = run ? cfg_pwm_full : '0;
        if (heater_active())
            st_mode = st_load ? MODE_HEATING : MODE_MONITOR;
    endfunction

    function automatic void clear_alarm();
        st_alarm  = htifsm_pkg::ALARM_NONE;
        st_buzzer = htifsm_pkg::ALARM_NONE;
    endfunction

    function automatic status_t interlock_event(input event_t ev);
        status_t                              r;
        logic                                 acc;
        logic signed [htifsm_pkg::TEMP_W-1:0] t;
        acc = 1'b0;
        t   = ev.temp;
        case (ev.op)
            htifsm_pkg::OP_FOUND:
            begin
                st_present = 1'b1;
                if (st_mode == MODE_SCAN || st_mode == MODE_SAFE)
                begin
                    st_mode = MODE_MONITOR;
                    clear_alarm();
                    st_load = 1'b0;
                end
                refresh_drive();
            end
            htifsm_pkg::OP_MISSING:
            begin
                st_present = 1'b0;
                st_load    = 1'b0;
                st_pwm     = '0;
                if (st_mode == MODE_SCAN)
                    st_mode = MODE_SAFE;
            end
            htifsm_pkg::OP_SAMPLE:
            begin
                st_reading_ok = ev.valid;
                st_reading    = ev.valid ? t : htifsm_pkg::INVALID_READING;
                if (!ev.valid)
                begin
                    if (heater_active() || st_mode == MODE_ALARM)
                    begin
                        st_load   = 1'b0;
                        st_mode   = MODE_SENSOR_FAIL;
                        st_alarm  = htifsm_pkg::ALARM_FAIL;
                        st_buzzer = htifsm_pkg::ALARM_FAIL;
                    end
                    st_pwm = '0;
                end
                else if (st_mode == MODE_SENSOR_FAIL || st_mode == MODE_SAFE)
                begin
                    st_mode = MODE_MONITOR;
                    clear_alarm();
                    st_load = 1'b0;
                    refresh_drive();
                end
                else if (st_mode == MODE_ALARM)
                begin
                    if (t < cfg_threshold)
                    begin
                        st_mode = MODE_MONITOR;
                        clear_alarm();
                        refresh_drive();
                    end
                end
                else if (t >= cfg_threshold)
                begin
                    st_load   = 1'b0;
                    st_mode   = MODE_ALARM;
                    st_alarm  = htifsm_pkg::ALARM_OVERHEAT;
                    st_buzzer = htifsm_pkg::ALARM_OVERHEAT;
                    st_pwm    = '0;
                end
                else
                    refresh_drive();
            end
            htifsm_pkg::OP_REQ_ON:
            begin
                if (heater_active() && st_reading_ok && st_reading < cfg_threshold)
                begin
                    st_load = 1'b1;
                    refresh_drive();
                    acc = 1'b1;
                end
            end
            htifsm_pkg::OP_REQ_OFF:
            begin
                if (heater_active())
                begin
                    st_load = 1'b0;
                    refresh_drive();
                    acc = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.mode     = st_mode;
        r.pwm      = st_pwm;
        r.load     = st_load;
        r.alarm    = st_alarm;
        r.buzzer   = st_buzzer;
        r.present  = st_present;
        r.accepted = acc;
        return r;
    endfunction

    task automatic check_field(input string fname, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("result %0d: %s expected %0d, got %0d",
                         results_seen, fname, exp_v, act_v);
        end
    endtask

    // predict on each accepted request, check each accepted result
    always @(posedge clk)
    begin
        status_t exp_s;
        req_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                status_q.push_back(interlock_event({s_tuser[2:0], s_tuser[3], s_tdata[11:0]}));
                events_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (status_q.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("result %0d: unexpected, data %h", results_seen, m_tdata);
                end
                else
                begin
                    exp_s = status_q.pop_front();
                    check_field("mode",           exp_s.mode,     m_tdata[2:0]);
                    check_field("pwm",            exp_s.pwm,      m_tdata[18:3]);
                    check_field("load_requested", exp_s.load,     m_tdata[19]);
                    check_field("alarm_code",     exp_s.alarm,    m_tdata[21:20]);
                    check_field("buzzer_code",    exp_s.buzzer,   m_tdata[23:22]);
                    check_field("sensor_present", exp_s.present,  m_tdata[24]);
                    check_field("accepted",       exp_s.accepted, m_tdata[25]);
                end
            end
        end
    end

    // request driver: bursts of random length with random gaps
    always @(negedge clk)
    begin
        event_t ev;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!(s_tvalid && !req_taken))
        begin
            if (drain_hold && results_seen == events_taken)
                drain_hold = 1'b0;
            if (gap_left != 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (drain_hold || event_q.size() == 0)
                s_tvalid <= 1'b0;
            else
            begin
                ev = event_q.pop_front();
                s_tdata  <= {4'b0000, ev.temp};
                s_tuser  <= {ev.valid, ev.op};
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    // hold off now and then until all results are back
                    if ($urandom_range(0, 19) == 0)
                        drain_hold = 1'b1;
                end
                else
                    burst_left--;
            end
        end
    end

    // result side: stall pattern is chosen at random and changed periodically
    always @(negedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt % 300 == 0)
            ready_style = $urandom_range(0, 3);
        case (ready_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (cycle_cnt % 4 == 0);
            default: m_tready <= ($urandom_range(0, 9) < 8);
        endcase
    end

    task automatic queue_event(input logic [htifsm_pkg::OP_W-1:0] op, input logic valid,
                               input logic [htifsm_pkg::TEMP_W-1:0] temp);
        event_q.push_back({op, valid, temp});
        events_queued++;
    endtask

    task automatic wait_drained();
        while (results_seen != events_queued)
            @(negedge clk);
        // latency margin before touching the registers
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == htifsm_pkg::REG_THRESHOLD)
            cfg_threshold = value[htifsm_pkg::TEMP_W-1:0];
        else
            cfg_pwm_full = value[htifsm_pkg::PWM_W-1:0];
        @(negedge clk);
    endtask

    function automatic logic [htifsm_pkg::TEMP_W-1:0] pick_temp();
        int t;
        case ($urandom_range(0, 9))
            0, 1, 2: t = $signed($urandom_range(0, 4095) - 2048);
            3, 4:    t = int'(cfg_threshold) - $urandom_range(1, 300);
            default: t = int'(cfg_threshold) + $urandom_range(0, 48) - 40;
        endcase
        if (t > 2047)
            t = 2047;
        if (t < -2048)
            t = -2048;
        return t[htifsm_pkg::TEMP_W-1:0];
    endfunction

    task automatic queue_random_event();
        logic [htifsm_pkg::OP_W-1:0] op;
        int unsigned                 roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            op = htifsm_pkg::OP_FOUND;
        else if (roll < 19)
            op = htifsm_pkg::OP_MISSING;
        else if (roll < 65)
            op = htifsm_pkg::OP_SAMPLE;
        else if (roll < 83)
            op = htifsm_pkg::OP_REQ_ON;
        else if (roll < 95)
            op = htifsm_pkg::OP_REQ_OFF;
        else
            op = htifsm_pkg::OP_W'($urandom_range(5, 7));
        if (op == htifsm_pkg::OP_SAMPLE)
            queue_event(op, $urandom_range(0, 99) >= 12, pick_temp());
        else
            queue_event(op, 1'($urandom_range(0, 1)),
                        htifsm_pkg::TEMP_W'($urandom_range(0, 4095)));
    endtask

    initial
    begin : stimulus
        logic signed [htifsm_pkg::TEMP_W-1:0] thr_set[6];
        logic [htifsm_pkg::PWM_W-1:0]         pwm_set[6];
        thr_set = '{12'sd2047, -12'sd2048, 12'sd0, 12'sd0, -12'sd1, 12'sd1280};
        pwm_set = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 16'h8000, 16'd255};
        thr_set[3] = htifsm_pkg::TEMP_W'($urandom_range(0, 4095));
        pwm_set[3] = htifsm_pkg::PWM_W'($urandom_range(0, 65535));
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // walk the modes under the reset configuration
        queue_event(3'd5, 1'b0, 12'h000);
        queue_event(3'd7, 1'b1, 12'hFFF);
        queue_event(htifsm_pkg::OP_REQ_ON, 1'b1, 12'h000);
        queue_event(htifsm_pkg::OP_REQ_OFF, 1'b0, 12'h000);
        queue_event(htifsm_pkg::OP_SAMPLE, 1'b1, 12'h000);
        queue_event(htifsm_pkg::OP_SAMPLE, 1'b0, 12'h123);
        queue_event(htifsm_pkg::OP_MISSING, 1'b0, 12'h000);
        queue_event(htifsm_pkg::OP_FOUND, 1'b0, 12'h000);
        queue_event(htifsm_pkg::OP_REQ_ON, 1'b0, 12'h000);
        queue_event(htifsm_pkg::OP_SAMPLE, 1'b1, 12'h000);
        queue_event(htifsm_pkg::OP_REQ_ON, 1'b0, 12'h000);
        queue_event(htifsm_pkg::OP_SAMPLE, 1'b1, 12'd1279);
        queue_event(htifsm_pkg::OP_SAMPLE, 1'b1, 12'd1280);
        queue_event(htifsm_pkg::OP_REQ_OFF, 1'b0, 12'h000);
        queue_event(htifsm_pkg::OP_SAMPLE, 1'b1, 12'h800);
        queue_event(htifsm_pkg::OP_REQ_ON, 1'b0, 12'h000);
        queue_event(htifsm_pkg::OP_SAMPLE, 1'b0, 12'h555);
        queue_event(htifsm_pkg::OP_FOUND, 1'b0, 12'h000);
        queue_event(htifsm_pkg::OP_SAMPLE, 1'b1, 12'hFFF);
        queue_event(htifsm_pkg::OP_REQ_ON, 1'b0, 12'h000);
        queue_event(htifsm_pkg::OP_MISSING, 1'b0, 12'h000);
        queue_event(htifsm_pkg::OP_REQ_OFF, 1'b0, 12'h000);
        queue_event(htifsm_pkg::OP_SAMPLE, 1'b1, 12'h7FF);
        queue_event(htifsm_pkg::OP_MISSING, 1'b0, 12'h000);
        queue_event(htifsm_pkg::OP_SAMPLE, 1'b0, 12'hAAA);
        queue_event(3'd6, 1'b1, 12'h7FF);
        repeat (120) queue_random_event();

        for (int p = 0; p < 6; p++)
        begin
            wait_drained();
            write_reg(htifsm_pkg::REG_THRESHOLD,
                      {{20{thr_set[p][htifsm_pkg::TEMP_W-1]}}, thr_set[p]});
            write_reg(htifsm_pkg::REG_PWM_FULL, {16'h0000, pwm_set[p]});
            // bring the sensor back and give a fresh sample before the random part
            queue_event(htifsm_pkg::OP_FOUND, 1'b0, 12'h000);
            queue_event(htifsm_pkg::OP_SAMPLE, 1'b1, pick_temp());
            repeat (118) queue_random_event();
        end

        while (results_seen != events_queued)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (status_q.size() != 0)
            n_mismatch += status_q.size();
        if (n_mismatch == 0)
            $display("heater_thermal_interlock_fsm_tb: PASS");
        else
            $display("heater_thermal_interlock_fsm_tb: FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("heater_thermal_interlock_fsm_tb: FAIL");
        $finish;
    end

endmodule
